### rtl/dda_line_rasterizer_unit_defines.svh
// ----------------------------------------------------------------------------
// DDA line rasterizer assertion macros
// Shared property shorthands for the rasterizer modules; clock i_clk, reset
// i_rst_n (active low) are assumed to exist in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DLR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dlr assertion failed");

// Next-cycle implication, disabled while reset is held.
`define DLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dlr assertion failed");

`endif

### rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Widths, fixed-point layout and the command passed from setup to walker.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int COORD_BITS = 6;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_W      = COORD_BITS + FRAC_BITS;
    localparam int INC_W      = FRAC_BITS + 2;
    localparam int CNT_W      = $clog2(ACC_W);
    // The command queue depth must be a power of two so the pointers wrap.
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [COORD_BITS-1:0]   start_x;
        logic [COORD_BITS-1:0]   start_y;
        logic [COORD_BITS-1:0]   steps;
        logic signed [INC_W-1:0] inc_x;
        logic signed [INC_W-1:0] inc_y;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_port;

endpackage

### rtl/dlr_front.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer setup stage
// Accepts a segment, finds the step count and divides both deltas by it.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_unit_defines.svh"

module dlr_front import dlr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output t_q_port               o_wr,
    input  logic                  i_q_full
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [COORD_BITS-1:0] r_sx, r_sy, r_steps;
    logic                  r_neg_x, r_neg_y;
    logic [ACC_W-1:0]      r_dvd_x, r_dvd_y;
    logic [COORD_BITS-1:0] r_rem_x, r_rem_y;
    logic [CNT_W-1:0]      r_cnt;

    logic [COORD_BITS-1:0] adx, ady;
    logic [COORD_BITS:0]   rsh_x, rsh_y, dsr;
    logic                  qx, qy;
    logic [COORD_BITS-1:0] n_rem_x, n_rem_y;
    logic [INC_W-1:0]      mag_x, mag_y;

    assign adx = (i_start_x >= i_end_x) ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
    assign ady = (i_start_y >= i_end_y) ? (i_start_y - i_end_y) : (i_end_y - i_start_y);

    // One restoring-division step per cycle on each axis. The dividend
    // register shifts left and collects quotient bits at its bottom.
    always_comb begin
        dsr     = {1'b0, r_steps};
        rsh_x   = {r_rem_x, r_dvd_x[ACC_W-1]};
        rsh_y   = {r_rem_y, r_dvd_y[ACC_W-1]};
        qx      = (rsh_x >= dsr);
        qy      = (rsh_y >= dsr);
        n_rem_x = qx ? COORD_BITS'(rsh_x - dsr) : rsh_x[COORD_BITS-1:0];
        n_rem_y = qy ? COORD_BITS'(rsh_y - dsr) : rsh_y[COORD_BITS-1:0];
        mag_x   = {1'b0, r_dvd_x[FRAC_BITS:0]};
        mag_y   = {1'b0, r_dvd_y[FRAC_BITS:0]};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_push) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!i_q_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_push) begin
                    r_sx    <= i_start_x;
                    r_sy    <= i_start_y;
                    r_steps <= (adx > ady) ? adx : ady;
                    r_neg_x <= (i_end_x < i_start_x);
                    r_neg_y <= (i_end_y < i_start_y);
                    r_dvd_x <= {adx, {FRAC_BITS{1'b0}}};
                    r_dvd_y <= {ady, {FRAC_BITS{1'b0}}};
                    r_rem_x <= '0;
                    r_rem_y <= '0;
                    r_cnt   <= CNT_W'(ACC_W - 1);
                end
            end
            S_DIV: begin
                r_dvd_x <= {r_dvd_x[ACC_W-2:0], qx};
                r_dvd_y <= {r_dvd_y[ACC_W-2:0], qy};
                r_rem_x <= n_rem_x;
                r_rem_y <= n_rem_y;
                r_cnt   <= r_cnt - 1'b1;
            end
            S_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    assign o_full            = (r_state != S_IDLE);
    assign o_wr.valid        = (r_state == S_PUSH);
    assign o_wr.cmd.start_x  = r_sx;
    assign o_wr.cmd.start_y  = r_sy;
    assign o_wr.cmd.steps    = r_steps;
    // A zero-length segment has no valid quotient; it gets zero increments.
    assign o_wr.cmd.inc_x    = (r_steps == '0) ? '0 : (r_neg_x ? -mag_x : mag_x);
    assign o_wr.cmd.inc_y    = (r_steps == '0) ? '0 : (r_neg_y ? -mag_y : mag_y);

    `DLR_ASSERT_NEXT(a_div_ends, (r_state == S_DIV) && (r_cnt == '0), r_state == S_PUSH)
    `DLR_ASSERT_IMPL(a_full_busy, r_state != S_IDLE, o_full)

endmodule

### rtl/dlr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer command queue
// Short queue of prepared segments between the setup and walk stages.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_unit_defines.svh"

module dlr_cmd_fifo import dlr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_port i_wr,
    output logic    o_full,
    output t_q_port o_rd,
    input  logic    i_take
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              wr_en, rd_en;

    assign o_full   = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign wr_en    = i_wr.valid && !o_full;
    assign rd_en    = i_take && (r_cnt != '0);
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wp] <= i_wr.cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= r_wp + 1'b1;
            if (rd_en) r_rp <= r_rp + 1'b1;
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `DLR_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= (Q_AW + 1)'(Q_DEPTH))

endmodule

### rtl/dlr_back.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer walk stage
// Steps the accumulators one point per cycle into a result register while that register is empty or being popped.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_unit_defines.svh"

module dlr_back import dlr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_port               i_rd,
    output logic                  o_take,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_point
);

    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic                    r_busy, r_out_valid;
    logic [ACC_W-1:0]        r_acc_x, r_acc_y;
    logic [INC_W-1:0]        r_inc_x, r_inc_y;
    logic [COORD_BITS-1:0]   r_left;
    logic [COORD_BITS-1:0]   r_px, r_py;
    logic                    r_last;

    logic                    load, emit;
    logic [ACC_W-1:0]        sum_x, sum_y, ext_x, ext_y;

    assign load  = !r_busy && i_rd.valid;
    assign emit  = r_busy && (!r_out_valid || i_pop);
    assign o_take = load;

    assign sum_x = r_acc_x + HALF;
    assign sum_y = r_acc_y + HALF;
    assign ext_x = {{(ACC_W - INC_W){r_inc_x[INC_W-1]}}, r_inc_x};
    assign ext_y = {{(ACC_W - INC_W){r_inc_y[INC_W-1]}}, r_inc_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && (r_left == '0)) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_acc_x <= {i_rd.cmd.start_x, {FRAC_BITS{1'b0}}};
            r_acc_y <= {i_rd.cmd.start_y, {FRAC_BITS{1'b0}}};
            r_inc_x <= i_rd.cmd.inc_x;
            r_inc_y <= i_rd.cmd.inc_y;
            r_left  <= i_rd.cmd.steps;
        end else if (emit) begin
            r_acc_x <= r_acc_x + ext_x;
            r_acc_y <= r_acc_y + ext_y;
            r_left  <= r_left - 1'b1;
        end
        if (emit) begin
            r_px   <= sum_x[ACC_W-1:FRAC_BITS];
            r_py   <= sum_y[ACC_W-1:FRAC_BITS];
            r_last <= (r_left == '0);
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_point = r_last;

    `DLR_ASSERT_NEXT(a_walk_ends, emit && (r_left == '0), !r_busy)
    `DLR_ASSERT_NEXT(a_emit_fills, emit, r_out_valid)

endmodule

### rtl/dda_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Walks a line segment in a 64 by 64 tile and returns its pixels in order.
// ----------------------------------------------------------------------------
// Usage:
// Both sides behave like a queue. A segment transaction is accepted at a clock
// edge with push high and full low; the endpoints come on i_start_x/y and
// i_end_x/y. Results are read like a queue as well: while empty is low the
// oldest point sits on o_pixel_x, o_pixel_y and o_last_point, and it leaves at
// an edge with pop high. A segment of N steps (the larger of |dx| and |dy|)
// yields N + 1 point transactions, the last one flagged.
// From accept, a segment passes through bit-serial division in the setup stage,
// the write into the queue, the load of the walker and the fill of the result
// register before its first point reaches the result ports.
// The setup stage holds full high and takes no new segment until it has passed
// the current one to the queue; the walker emits one point per cycle while the
// receiver keeps popping, with a load step between segments.
// Reset (synchronous, active low) empties the command queue, idles both
// stages and drops any pending result. When the receiver stalls, the result
// register holds its point, the walker waits, the queue fills and full rises.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit import dlr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_point
);

    // Prepared commands flow setup -> queue -> walker.
    t_q_port wr_port, rd_port;
    logic    q_full, q_take;

    // Setup: step count, signs and per-axis increments by long division.
    dlr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_wr      (wr_port),
        .i_q_full  (q_full)
    );

    // Decoupling queue so that division of the next segment overlaps the walk.
    dlr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr_port),
        .o_full  (q_full),
        .o_rd    (rd_port),
        .i_take  (q_take)
    );

    // Walker: accumulates the fixed-point position and rounds each point.
    dlr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd         (rd_port),
        .o_take       (q_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_point (o_last_point)
    );

endmodule
